[rtl/trng_bht_pkg.sv]
// trng_bht_pkg: shared types, constants and register indexes for the
// entropy bit health tests. No dependencies; imported by every rtl module.
`timescale 1ns / 1ps

package trng_bht_pkg;

    // default sizing of the test counters
    localparam int DEF_MAX_WINDOW    = 4096;
    localparam int DEF_RUN_COUNT_MAX = 255;

    // configuration field widths
    localparam int REPEAT_CUTOFF_W = 8;
    localparam int WINDOW_SIZE_W   = 13;
    localparam int PROP_CUTOFF_W   = 13;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_INDEX_W     = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_REPEAT_CUTOFF = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WINDOW_SIZE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PROP_CUTOFF   = 2'd2;

    // reset values of the configuration registers
    localparam logic [REPEAT_CUTOFF_W-1:0] RST_REPEAT_CUTOFF = 8'd21;
    localparam logic [WINDOW_SIZE_W-1:0]   RST_WINDOW_SIZE   = 13'd1024;
    localparam logic [PROP_CUTOFF_W-1:0]   RST_PROP_CUTOFF   = 13'd589;

    // current configuration
    typedef struct packed {
        logic [REPEAT_CUTOFF_W-1:0] repeat_cutoff;
        logic [WINDOW_SIZE_W-1:0]   window_size;
        logic [PROP_CUTOFF_W-1:0]   proportion_cutoff;
    } cfg_t;

    // per-bit control handed to both tests
    typedef struct packed {
        logic step;        // bit leaves the input stage, commit state
        logic start;       // first bit of a new block
        logic sample_bit;
    } test_ctl_t;

endpackage

[rtl/trng_bit_health_tests.sv]
// trng_bit_health_tests: top level of the entropy bit health tests.
// Depends on trng_bht_pkg, trng_bht_cfg_regs, trng_bht_rct and trng_bht_apt.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one raw entropy bit per transaction (s_sample_bit), with
//   s_block_last marking the last bit of a tested block.
//   m_ channel: one verdict per input transaction, in order: repetition
//   fail, proportion fail, sticky block fail and block done.
//   cfg channel: register writes (index 0 repeat cutoff, 1 window size,
//   2 proportion cutoff); always ready; write only while the block is idle.
// Timing
//   a bit taken is held in the input register, and its verdict is loaded
//   into the result register when the input stage advances, which waits
//   while a full result register is not being emptied.
//   one transaction per cycle sustained while m_ready stays high; the test
//   state update is combinational logic from the input to the result register.
// Reset and stall
//   reset clears all test state and loads the default configuration; the
//   first bit after reset opens a new block.
//   when m_ready is low the result register holds, the input register
//   holds its bit, and s_ready drops once both are full.

module trng_bit_health_tests
    import trng_bht_pkg::*;
#(
    parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
    parameter int RUN_COUNT_MAX = DEF_RUN_COUNT_MAX
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_sample_bit,
    input  logic                   s_block_last,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_repeat_fail,
    output logic                   m_proportion_fail,
    output logic                   m_block_failed,
    output logic                   m_block_done,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    test_ctl_t ctl;

    logic in_valid_reg;
    logic in_bit_reg;
    logic in_last_reg;
    logic out_valid_reg;
    logic out_repeat_reg;
    logic out_prop_reg;
    logic out_failed_reg;
    logic out_done_reg;
    logic block_open_reg;
    logic block_open_next;
    logic fail_seen_reg;
    logic fail_seen_next;
    logic advance;
    logic repeat_fail;
    logic proportion_fail;
    logic failed;

    // configuration registers
    trng_bht_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input stage moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign ctl.step       = advance;
    assign ctl.start      = !block_open_reg;
    assign ctl.sample_bit = in_bit_reg;

    // the two tests
    trng_bht_rct #(
        .RUN_COUNT_MAX (RUN_COUNT_MAX)
    ) u_rct (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .repeat_cutoff (cfg.repeat_cutoff),
        .repeat_fail   (repeat_fail)
    );

    trng_bht_apt #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_apt (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .window_size       (cfg.window_size),
        .proportion_cutoff (cfg.proportion_cutoff),
        .proportion_fail   (proportion_fail)
    );

    // sticky block verdict and block framing
    assign failed          = fail_seen_reg || repeat_fail || proportion_fail;
    assign block_open_next = !in_last_reg;
    assign fail_seen_next  = in_last_reg ? 1'b0 : failed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_open_reg <= 1'b0;
            fail_seen_reg  <= 1'b0;
        end else if (advance) begin
            block_open_reg <= block_open_next;
            fail_seen_reg  <= fail_seen_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_bit_reg  <= s_sample_bit;
            in_last_reg <= s_block_last;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_repeat_reg <= repeat_fail;
            out_prop_reg   <= proportion_fail;
            out_failed_reg <= failed;
            out_done_reg   <= in_last_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_repeat_fail     = out_repeat_reg;
    assign m_proportion_fail = out_prop_reg;
    assign m_block_failed    = out_failed_reg;
    assign m_block_done      = out_done_reg;

    // checks

    // a failing transaction always carries the sticky flag
    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_repeat_fail || m_proportion_fail) |-> m_block_failed)
        else $error("block_failed missing on a failing transaction");

    // closing a block clears the framing state
    a_block_close: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> !block_open_reg && !fail_seen_reg)
        else $error("block state not cleared after the last bit");

    // zero window or zero cutoff fails every transaction
    a_cfg_error: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ((cfg.window_size == '0) || (cfg.proportion_cutoff == '0))
        |=> m_proportion_fail)
        else $error("configuration error not flagged");

    // a held input bit is never dropped
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input bit lost while stalled");

endmodule

[rtl/trng_bht_cfg_regs.sv]
// trng_bht_cfg_regs: configuration register file of the health tests.
// Depends on trng_bht_pkg.
`timescale 1ns / 1ps

module trng_bht_cfg_regs
    import trng_bht_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg          = cfg_reg;

    // decode the register index, unknown indexes are ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_REPEAT_CUTOFF: cfg_next.repeat_cutoff = cfg_data[REPEAT_CUTOFF_W-1:0];
                CFG_IDX_WINDOW_SIZE:   cfg_next.window_size   = cfg_data[WINDOW_SIZE_W-1:0];
                CFG_IDX_PROP_CUTOFF:   cfg_next.proportion_cutoff = cfg_data[PROP_CUTOFF_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_cutoff     <= RST_REPEAT_CUTOFF;
            cfg_reg.window_size       <= RST_WINDOW_SIZE;
            cfg_reg.proportion_cutoff <= RST_PROP_CUTOFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/trng_bht_rct.sv]
// trng_bht_rct: repetition count test, tracks the run of equal bits.
// Depends on trng_bht_pkg.
`timescale 1ns / 1ps

module trng_bht_rct
    import trng_bht_pkg::*;
#(
    parameter int RUN_COUNT_MAX = DEF_RUN_COUNT_MAX
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  test_ctl_t                  ctl,
    input  logic [REPEAT_CUTOFF_W-1:0] repeat_cutoff,
    output logic                       repeat_fail
);

    localparam int RW = $clog2(RUN_COUNT_MAX + 1);
    localparam int CW = (RW > REPEAT_CUTOFF_W) ? RW : REPEAT_CUTOFF_W;

    logic          run_value_reg;
    logic          run_value_next;
    logic [RW-1:0] run_count_reg;
    logic [RW-1:0] run_count_next;
    logic [RW-1:0] run_count_inc;

    assign run_count_inc = run_count_reg + RW'(1);

    // new run on block start or bit change, else count up to saturation
    always_comb begin
        run_value_next = run_value_reg;
        run_count_next = run_count_reg;
        repeat_fail    = 1'b0;
        if (ctl.start || (ctl.sample_bit != run_value_reg)) begin
            run_value_next = ctl.sample_bit;
            run_count_next = RW'(1);
        end else if (run_count_reg < RW'(RUN_COUNT_MAX)) begin
            run_count_next = run_count_inc;
            repeat_fail    = (CW'(run_count_inc) == CW'(repeat_cutoff));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_value_reg <= 1'b0;
            run_count_reg <= '0;
        end else if (ctl.step) begin
            run_value_reg <= run_value_next;
            run_count_reg <= run_count_next;
        end
    end

endmodule

[rtl/trng_bht_apt.sv]
// trng_bht_apt: adaptive proportion test over windows of configured size.
// Depends on trng_bht_pkg.
`timescale 1ns / 1ps

module trng_bht_apt
    import trng_bht_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  test_ctl_t                ctl,
    input  logic [WINDOW_SIZE_W-1:0] window_size,
    input  logic [PROP_CUTOFF_W-1:0] proportion_cutoff,
    output logic                     proportion_fail
);

    localparam int WW  = $clog2(MAX_WINDOW + 1);
    localparam int CW0 = (WW > WINDOW_SIZE_W) ? WW : WINDOW_SIZE_W;
    localparam int CW  = (CW0 > PROP_CUTOFF_W) ? CW0 : PROP_CUTOFF_W;

    logic          window_ref_reg;
    logic          window_ref_next;
    logic [WW-1:0] window_count_reg;
    logic [WW-1:0] window_count_next;
    logic [WW-1:0] window_index_reg;
    logic [WW-1:0] window_index_next;
    logic [WW-1:0] index_cur;
    logic [CW-1:0] win_eff;
    logic          restart;
    logic          window_end_fail;
    logic          cfg_error;

    // window size clamped to the largest supported window
    assign win_eff = (CW'(window_size) > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW)
                                                         : CW'(window_size);
    assign restart   = ctl.start || (CW'(window_index_reg) >= win_eff);
    assign cfg_error = (window_size == '0) || (proportion_cutoff == '0);

    // window bookkeeping, verdict at the last bit of the window, and a fail on every bit under a zero window or cutoff
    always_comb begin
        window_ref_next   = window_ref_reg;
        window_count_next = window_count_reg;
        index_cur         = window_index_reg;
        if (restart) begin
            window_ref_next   = ctl.sample_bit;
            window_count_next = WW'(1);
            index_cur         = '0;
        end else if ((ctl.sample_bit == window_ref_reg)
                     && (window_count_reg < WW'(MAX_WINDOW))) begin
            window_count_next = window_count_reg + WW'(1);
        end
        window_end_fail = (win_eff != '0)
                          && (CW'(index_cur) == (win_eff - CW'(1)))
                          && (CW'(window_count_next) > CW'(proportion_cutoff));
        window_index_next = (index_cur < WW'(MAX_WINDOW)) ? (index_cur + WW'(1))
                                                          : index_cur;
        proportion_fail   = window_end_fail || cfg_error;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ref_reg   <= 1'b0;
            window_count_reg <= '0;
            window_index_reg <= '0;
        end else if (ctl.step) begin
            window_ref_reg   <= window_ref_next;
            window_count_reg <= window_count_next;
            window_index_reg <= window_index_next;
        end
    end

endmodule

[verif/tb.sv]
// tb: self-checking testbench for trng_bit_health_tests, predicting every verdict
// with its own model of the repetition and proportion tests and checking results in order
// depends on trng_bht_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb;
    import trng_bht_pkg::*;

    localparam int MAX_WIN      = DEF_MAX_WINDOW;
    localparam int RUN_MAX      = DEF_RUN_COUNT_MAX;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    // index with no register behind it, writes are ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        int   seq;
        logic repeat_fail;
        logic proportion_fail;
        logic block_failed;
        logic block_done;
    } verdict_t;

    // dut inputs, known from time zero
    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_sample_bit = 1'b0;
    logic                   s_block_last = 1'b0;
    logic                   m_ready      = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // dut outputs
    logic s_ready;
    logic m_valid;
    logic m_repeat_fail;
    logic m_proportion_fail;
    logic m_block_failed;
    logic m_block_done;
    logic cfg_ready;

    // configuration as the block should hold it
    logic [REPEAT_CUTOFF_W-1:0] cur_repeat_cutoff = RST_REPEAT_CUTOFF;
    logic [WINDOW_SIZE_W-1:0]   cur_window_size   = RST_WINDOW_SIZE;
    logic [PROP_CUTOFF_W-1:0]   cur_prop_cutoff   = RST_PROP_CUTOFF;

    // test state as the block should hold it
    logic        in_block     = 1'b0;
    logic        run_bit      = 1'b0;
    logic [7:0]  run_len      = '0;
    logic        win_ref_bit  = 1'b0;
    logic [12:0] win_ref_hits = '0;
    logic [12:0] win_pos      = '0;
    logic        block_fail   = 1'b0;

    verdict_t expected_verdicts[$];

    int mismatch_count   = 0;
    int bits_accepted    = 0;
    int verdicts_checked = 0;
    int reg_writes       = 0;
    int idle_cycles      = 0;

    // traffic knobs
    int src_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_req  = 0;
    int rx_hold_left = 0;

    always #2 aclk = ~aclk;

    trng_bit_health_tests DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_bit      (s_sample_bit),
        .s_block_last      (s_block_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_repeat_fail     (m_repeat_fail),
        .m_proportion_fail (m_proportion_fail),
        .m_block_failed    (m_block_failed),
        .m_block_done      (m_block_done),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // verdict for one bit, advancing both health tests
    function automatic verdict_t predict_verdict(input logic b, input logic last);
        verdict_t v;
        int       win;
        v   = '0;
        win = (int'(cur_window_size) > MAX_WIN) ? MAX_WIN : int'(cur_window_size);

        // repetition count
        if (!in_block || b != run_bit) begin
            run_bit = b;
            run_len = 8'd1;
        end else if (int'(run_len) < RUN_MAX) begin
            run_len = run_len + 8'd1;
            if (run_len == cur_repeat_cutoff)
                v.repeat_fail = 1'b1;
        end

        // adaptive proportion
        if (!in_block || int'(win_pos) >= win) begin
            win_ref_bit  = b;
            win_ref_hits = 13'd1;
            win_pos      = '0;
        end else if (b == win_ref_bit && int'(win_ref_hits) < MAX_WIN) begin
            win_ref_hits = win_ref_hits + 13'd1;
        end
        if (win != 0 && int'(win_pos) == win - 1 && win_ref_hits > cur_prop_cutoff)
            v.proportion_fail = 1'b1;
        if (int'(win_pos) < MAX_WIN)
            win_pos = win_pos + 13'd1;
        if (cur_window_size == '0 || cur_prop_cutoff == '0)
            v.proportion_fail = 1'b1;

        v.block_failed = block_fail | v.repeat_fail | v.proportion_fail;
        v.block_done   = last;

        // block bookkeeping
        if (last) begin
            in_block   = 1'b0;
            block_fail = 1'b0;
        end else begin
            in_block   = 1'b1;
            block_fail = v.block_failed;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string field, input int seq, input logic got,
                               input logic want);
        if (got !== want)
            report_mismatch($sformatf("bit %0d %s got %b want %b", seq, field, got, want));
    endtask

    // monitor: check results first, then predict the bit taken at this edge
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result transaction with no bit outstanding");
                end else begin
                    want = expected_verdicts.pop_front();
                    verdicts_checked++;
                    check_field("repeat_fail", want.seq, m_repeat_fail, want.repeat_fail);
                    check_field("proportion_fail", want.seq, m_proportion_fail,
                                want.proportion_fail);
                    check_field("block_failed", want.seq, m_block_failed, want.block_failed);
                    check_field("block_done", want.seq, m_block_done, want.block_done);
                end
            end
            if (s_valid && s_ready) begin
                want     = predict_verdict(s_sample_bit, s_block_last);
                want.seq = bits_accepted;
                expected_verdicts.push_back(want);
                bits_accepted++;
            end
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (cfg_index)
                    CFG_IDX_REPEAT_CUTOFF: cur_repeat_cutoff = cfg_data[REPEAT_CUTOFF_W-1:0];
                    CFG_IDX_WINDOW_SIZE:   cur_window_size   = cfg_data[WINDOW_SIZE_W-1:0];
                    CFG_IDX_PROP_CUTOFF:   cur_prop_cutoff   = cfg_data[PROP_CUTOFF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic set_idle(input int src_pct, input int rx_pct);
        src_idle_pct = src_pct;
        rx_stall_pct = rx_pct;
    endtask

    // offer one bit, with random idle cycles in front
    task automatic send_bit(input logic b, input logic last);
        @(negedge aclk);
        while (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_sample_bit <= b;
        s_block_last <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // bits given lsb first
    task automatic send_pattern(input logic [31:0] bits, input logic [31:0] lasts, input int n);
        for (int i = 0; i < n; i++)
            send_bit(bits[i], lasts[i]);
    endtask

    // one block of len bits; stick_pct biases towards repeating the previous bit
    task automatic send_block(input int len, input int stick_pct);
        logic b;
        b = 1'($urandom_range(1, 0));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99, 0) >= stick_pct)
                b = 1'($urandom_range(1, 0));
            send_bit(b, i == len - 1);
        end
    endtask

    // stop offering and let every outstanding verdict come back
    task automatic drain_verdicts();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_verdicts();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int rep, input int win, input int prop);
        write_reg(CFG_IDX_REPEAT_CUTOFF, CFG_DATA_W'(rep));
        write_reg(CFG_IDX_WINDOW_SIZE, CFG_DATA_W'(win));
        write_reg(CFG_IDX_PROP_CUTOFF, CFG_DATA_W'(prop));
    endtask

    // defaults after reset: a run of 22 equal bits crosses the default cutoff
    task automatic test_reset_defaults();
        set_idle(0, 0);
        for (int i = 0; i < 22; i++)
            send_bit(1'b1, i == 21);
        send_bit(1'b0, 1'b1);
    endtask

    // runs hitting the cutoff once, block end and restart of both tests
    task automatic test_runs_and_blocks();
        configure(3, 4, 2);
        send_pattern(32'b1000011111, 32'b1001000000, 10);
    endtask

    // zero window, zero proportion cutoff, cutoffs that never fail, spare index
    task automatic test_config_errors();
        configure(0, 0, 5);
        send_pattern(32'b1000, 32'b1000, 4);
        write_reg(CFG_IDX_REPEAT_CUTOFF, 13'h1F01);
        write_reg(CFG_IDX_WINDOW_SIZE, 13'd4);
        write_reg(CFG_IDX_PROP_CUTOFF, 13'd0);
        send_pattern(32'b1111, 32'b1000, 4);
        write_reg(CFG_IDX_SPARE, 13'h1FFF);
        send_pattern(32'b01, 32'b10, 2);
    endtask

    // window shrunk under the current position, then a partial window at block end
    task automatic test_window_shrink();
        configure(2, 16, 16);
        send_pattern(32'b0101010101, 32'b0, 10);
        write_reg(CFG_IDX_WINDOW_SIZE, 13'd4);
        send_pattern(32'b111111, 32'b100000, 6);
        configure(2, 8, 1);
        send_pattern(32'b11111, 32'b10000, 5);
    endtask

    // receiver holds off while bits keep coming, so the input side stalls
    task automatic test_backpressure();
        configure(5, 8, 5);
        set_idle(0, 0);
        rx_hold_req = HOLD_CYCLES;
        send_block(60, 80);
        send_block(40, 50);
    endtask

    // run counter saturation under a window set above the largest size
    task automatic test_saturation_and_clamp();
        configure(RUN_MAX, 8191, 2048);
        set_idle(0, 0);
        for (int i = 0; i < RUN_MAX + 16; i++)
            send_bit(1'b1, i == RUN_MAX + 15);
    endtask

    function automatic int pick_repeat();
        int r;
        r = $urandom_range(99, 0);
        if (r < 8)  return 0;
        if (r < 14) return 1;
        if (r < 20) return RUN_MAX;
        return $urandom_range(12, 2);
    endfunction

    function automatic int pick_window();
        int r;
        r = $urandom_range(99, 0);
        if (r < 5)  return 0;
        if (r < 10) return 8191;
        if (r < 13) return MAX_WIN;
        if (r < 18) return 1;
        return $urandom_range(32, 2);
    endfunction

    function automatic int pick_prop(input int win);
        int r;
        r = $urandom_range(99, 0);
        if (r < 5)  return 0;
        if (r < 10) return 8191;
        return $urandom_range((win < 1) ? 1 : win, 1);
    endfunction

    // random blocks under random settings, cycling through the idle phases
    task automatic test_random_blocks();
        int sent;
        int len;
        int r;
        int win;
        for (int round = 0; round < 8; round++) begin
            case (round % 4)
                0: set_idle(0, 0);
                1: set_idle(64, 0);
                2: set_idle(0, 64);
                default: set_idle(9, 9);
            endcase
            win = pick_window();
            configure(pick_repeat(), win, pick_prop(win));
            sent = 0;
            while (sent < 90) begin
                r = $urandom_range(99, 0);
                if (r < 10)
                    len = 1;
                else if (r < 80)
                    len = $urandom_range(40, 2);
                else
                    len = $urandom_range(120, 41);
                send_block(len, $urandom_range(95, 0));
                sent += len;
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_runs_and_blocks();
        test_config_errors();
        test_window_shrink();
        test_backpressure();
        test_saturation_and_clamp();
        test_random_blocks();
        drain_verdicts();
        $display("%0d bits sent and %0d verdicts checked across %0d register writes,",
                 bits_accepted, verdicts_checked, reg_writes);
        $display("with idle and stall phases, a long hold-off and %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
rtl/trng_bht_pkg.sv
rtl/trng_bht_cfg_regs.sv
rtl/trng_bht_rct.sv
rtl/trng_bht_apt.sv
rtl/trng_bit_health_tests.sv
verif/tb.sv
